// ----- hw/rtl/sdtq_pkg.sv -----
// Shared types and constants of the sorted deadline timer queue.
`default_nettype none

package sdtq_pkg;

  localparam int unsigned SLOT_W = 6;
  localparam int unsigned IO_TIME_W = 32;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_ADJUST = 2'd1,
    OP_DELETE = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_ABSENT  = 2'd2,
    STS_PRESENT = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    ACT_HOLD   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_POP    = 2'd3
  } act_e;

  typedef enum logic [2:0] {
    ST_IDLE     = 3'd0,
    ST_LOOKUP   = 3'd1,
    ST_DECIDE   = 3'd2,
    ST_REINSERT = 3'd3,
    ST_TICK     = 3'd4
  } state_e;

  typedef struct packed {
    act_e              act;
    logic [SLOT_W-1:0] slot;
  } cell_cmd_t;

  typedef struct packed {
    logic              full;
    logic              head_exp;
    logic              next_exp;
    logic [SLOT_W-1:0] head_slot;
  } chain_sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sdtq_cell.sv -----
// One cell of the sorted timer chain: slot id, deadline and occupancy.
`default_nettype none

module sdtq_cell
  import sdtq_pkg::*;
#(
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire cell_cmd_t            cmd_i,
  input  wire logic [TIME_BITS-1:0] key_i,
  input  wire logic                 del_from_i,
  input  wire logic [SLOT_W-1:0]    left_slot_i,
  input  wire logic [TIME_BITS-1:0] left_dl_i,
  input  wire logic                 left_occ_i,
  input  wire logic                 left_gt_i,
  input  wire logic [SLOT_W-1:0]    right_slot_i,
  input  wire logic [TIME_BITS-1:0] right_dl_i,
  input  wire logic                 right_occ_i,
  output logic [SLOT_W-1:0]         slot_o,
  output logic [TIME_BITS-1:0]      dl_o,
  output logic                      occ_o,
  output logic                      gt_o,
  output logic                      match_o
);

  logic [SLOT_W-1:0]    slot_q, slot_d;
  logic [TIME_BITS-1:0] dl_q, dl_d;
  logic                 occ_q, occ_d;
  logic                 gt;

  assign gt = !occ_q || (dl_q > key_i);

  always_comb begin
    slot_d = slot_q;
    dl_d   = dl_q;
    occ_d  = occ_q;
    case (cmd_i.act)
      ACT_INSERT: begin
        if (gt) begin
          if (!left_gt_i) begin
            slot_d = cmd_i.slot;
            dl_d   = key_i;
            occ_d  = 1'b1;
          end else begin
            slot_d = left_slot_i;
            dl_d   = left_dl_i;
            occ_d  = left_occ_i;
          end
        end
      end
      ACT_REMOVE: begin
        if (del_from_i) begin
          slot_d = right_slot_i;
          dl_d   = right_dl_i;
          occ_d  = right_occ_i;
        end
      end
      ACT_POP: begin
        slot_d = right_slot_i;
        dl_d   = right_dl_i;
        occ_d  = right_occ_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    dl_q   <= dl_d;
  end

  assign slot_o  = slot_q;
  assign dl_o    = dl_q;
  assign occ_o   = occ_q;
  assign gt_o    = gt;
  assign match_o = occ_q && (slot_q == cmd_i.slot);

endmodule

`default_nettype wire

// ----- hw/rtl/sdtq_ctrl.sv -----
// Command sequencer and result register of the sorted timer queue.
`default_nettype none

module sdtq_ctrl
  import sdtq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [SLOT_W-1:0]    timer_slot_i,
  input  wire logic [IO_TIME_W-1:0] deadline_i,
  input  wire logic [IO_TIME_W-1:0] current_time_i,
  input  wire logic [CAPACITY-1:0]  match_i,
  input  wire chain_sts_t           sts_i,
  output cell_cmd_t                 cmd_o,
  output logic [TIME_BITS-1:0]      key_o,
  output logic [CAPACITY-1:0]       del_from_o,
  output logic                      result_valid_o,
  output logic [SLOT_W-1:0]         expired_slot_o,
  output logic                      expired_flag_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  function automatic logic [CAPACITY-1:0] prefix_or(input logic [CAPACITY-1:0] v);
    logic [CAPACITY-1:0] p;
    p = v;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      p = p | (p << s);
    end
    return p;
  endfunction

  state_e               state_q, state_d;
  op_e                  op_q;
  logic [SLOT_W-1:0]    slot_q;
  logic [TIME_BITS-1:0] key_q;
  logic [CAPACITY-1:0]  match_q;
  logic [63:0]          dl_wide, now_wide;
  op_e                  op_in;
  logic                 hit;

  logic                 res_valid_q, res_valid_d;
  logic [SLOT_W-1:0]    res_slot_q, res_slot_d;
  logic                 res_flag_q, res_flag_d;
  status_e              res_status_q, res_status_d;
  logic                 res_last_q, res_last_d;

  assign op_in    = op_e'(opcode_i);
  assign dl_wide  = {{(64 - IO_TIME_W){1'b0}}, deadline_i};
  assign now_wide = {{(64 - IO_TIME_W){1'b0}}, current_time_i};
  assign hit      = |match_q;

  always_comb begin
    state_d      = state_q;
    cmd_o.act    = ACT_HOLD;
    cmd_o.slot   = slot_q;
    res_valid_d  = 1'b0;
    res_slot_d   = '0;
    res_flag_d   = 1'b0;
    res_status_d = STS_OK;
    res_last_d   = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = (op_in == OP_TICK) ? ST_TICK : ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
        case (op_q)
          OP_ADD: begin
            if (hit) begin
              res_status_d = STS_PRESENT;
            end else if (sts_i.full) begin
              res_status_d = STS_FULL;
            end else begin
              cmd_o.act = ACT_INSERT;
            end
          end
          OP_ADJUST, OP_DELETE: begin
            if (!hit) begin
              res_status_d = STS_ABSENT;
            end else begin
              cmd_o.act = ACT_REMOVE;
              if (op_q == OP_ADJUST) begin
                res_valid_d = 1'b0;
                state_d     = ST_REINSERT;
              end
            end
          end
          default: begin
          end
        endcase
      end
      ST_REINSERT: begin
        cmd_o.act   = ACT_INSERT;
        res_valid_d = 1'b1;
        state_d     = ST_IDLE;
      end
      ST_TICK: begin
        res_valid_d = 1'b1;
        if (sts_i.head_exp) begin
          cmd_o.act  = ACT_POP;
          res_slot_d = sts_i.head_slot;
          res_flag_d = 1'b1;
          res_last_d = !sts_i.next_exp;
          if (!sts_i.next_exp) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && start_i) begin
      op_q   <= op_in;
      slot_q <= timer_slot_i;
      key_q  <= (op_in == OP_TICK) ? now_wide[TIME_BITS-1:0] : dl_wide[TIME_BITS-1:0];
    end
    if (state_q == ST_LOOKUP) begin
      match_q <= match_i;
    end
    res_slot_q   <= res_slot_d;
    res_flag_q   <= res_flag_d;
    res_status_q <= res_status_d;
    res_last_q   <= res_last_d;
  end

  assign busy_o         = (state_q != ST_IDLE);
  assign key_o          = key_q;
  assign del_from_o     = prefix_or(match_q);
  assign result_valid_o = res_valid_q;
  assign expired_slot_o = res_slot_q;
  assign expired_flag_o = res_flag_q;
  assign status_o       = res_status_q;
  assign last_o         = res_last_q;

`ifndef SYNTHESIS
  a_beat_from_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy_o))
    else $error("result beat without a command in flight");
  a_expiry_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && expired_flag_o |-> status_o == STS_OK)
    else $error("expiry beat with error status");
  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> busy_o)
    else $error("non-final beat while idle");
`endif

endmodule

`default_nettype wire

// ----- hw/rtl/sorted_deadline_timer_queue_core.sv -----
// Top level of the sorted deadline timer queue: sequencer and cell chain.
//
// Channel   Direction  Handshake                 Payload
// command   in         start_i && !busy_o        opcode_i, timer_slot_i, deadline_i,
//                                                current_time_i
// result    out        result_valid_o (1 cycle)  expired_slot_o, expired_flag_o,
//                                                status_o, last_o
//
// Add, delete and a refused adjust go through the lookup and decide states, and the
// result beat is registered from decide; a done adjust adds a re-insert through the chain.
// A tick gives its beats from the tick state, one beat per cycle, one per expired timer
// popped off the head cell, or one beat with expired_flag_o low when none has expired.
// Reset is asynchronous and clears only occupancy and control; no clearing pass.
// The receiver cannot stall; a new command may be accepted while a beat shows.
`default_nettype none

module sorted_deadline_timer_queue_core
  import sdtq_pkg::*;
#(
  parameter int unsigned CAPACITY  = 64,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  output logic                      busy_o,
  input  wire logic [1:0]           opcode_i,
  input  wire logic [SLOT_W-1:0]    timer_slot_i,
  input  wire logic [IO_TIME_W-1:0] deadline_i,
  input  wire logic [IO_TIME_W-1:0] current_time_i,
  output logic                      result_valid_o,
  output logic [SLOT_W-1:0]         expired_slot_o,
  output logic                      expired_flag_o,
  output logic [1:0]                status_o,
  output logic                      last_o
);

  cell_cmd_t            cmd;
  chain_sts_t           sts;
  logic [TIME_BITS-1:0] key;
  logic [CAPACITY-1:0]  del_from;
  logic [CAPACITY-1:0]  match_vec;
  logic [CAPACITY-1:0]  occ_vec;
  logic [CAPACITY-1:0]  gt_vec;
  logic [SLOT_W-1:0]    slot_w [CAPACITY];
  logic [TIME_BITS-1:0] dl_w   [CAPACITY];
  logic [SLOT_W-1:0]    l_slot [CAPACITY];
  logic [TIME_BITS-1:0] l_dl   [CAPACITY];
  logic [CAPACITY-1:0]  l_occ;
  logic [CAPACITY-1:0]  l_gt;
  logic [SLOT_W-1:0]    r_slot [CAPACITY];
  logic [TIME_BITS-1:0] r_dl   [CAPACITY];
  logic [CAPACITY-1:0]  r_occ;

  sdtq_ctrl #(
    .CAPACITY (CAPACITY),
    .TIME_BITS(TIME_BITS)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .timer_slot_i  (timer_slot_i),
    .deadline_i    (deadline_i),
    .current_time_i(current_time_i),
    .match_i       (match_vec),
    .sts_i         (sts),
    .cmd_o         (cmd),
    .key_o         (key),
    .del_from_o    (del_from),
    .result_valid_o(result_valid_o),
    .expired_slot_o(expired_slot_o),
    .expired_flag_o(expired_flag_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign l_slot[i] = '0;
      assign l_dl[i]   = '0;
      assign l_occ[i]  = 1'b0;
      assign l_gt[i]   = 1'b0;
    end else begin : g_mid
      assign l_slot[i] = slot_w[i-1];
      assign l_dl[i]   = dl_w[i-1];
      assign l_occ[i]  = occ_vec[i-1];
      assign l_gt[i]   = gt_vec[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign r_slot[i] = '0;
      assign r_dl[i]   = '0;
      assign r_occ[i]  = 1'b0;
    end else begin : g_body
      assign r_slot[i] = slot_w[i+1];
      assign r_dl[i]   = dl_w[i+1];
      assign r_occ[i]  = occ_vec[i+1];
    end

    sdtq_cell #(
      .TIME_BITS(TIME_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .key_i       (key),
      .del_from_i  (del_from[i]),
      .left_slot_i (l_slot[i]),
      .left_dl_i   (l_dl[i]),
      .left_occ_i  (l_occ[i]),
      .left_gt_i   (l_gt[i]),
      .right_slot_i(r_slot[i]),
      .right_dl_i  (r_dl[i]),
      .right_occ_i (r_occ[i]),
      .slot_o      (slot_w[i]),
      .dl_o        (dl_w[i]),
      .occ_o       (occ_vec[i]),
      .gt_o        (gt_vec[i]),
      .match_o     (match_vec[i])
    );
  end

  assign sts.full      = occ_vec[CAPACITY-1];
  assign sts.head_exp  = !gt_vec[0];
  assign sts.next_exp  = !gt_vec[1];
  assign sts.head_slot = slot_w[0];

`ifndef SYNTHESIS
  a_occ_packed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec >> 1) & ~occ_vec) == '0)
    else $error("occupied cells not packed at the head");
  a_pop_expired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.act == ACT_POP |-> occ_vec[0] && !gt_vec[0])
    else $error("pop of a head timer that has not expired");
  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.act == ACT_INSERT |-> !occ_vec[CAPACITY-1])
    else $error("insert into a full chain");
`endif

endmodule

`default_nettype wire

// ----- verif/timer_queue_checker.sv -----
// Checker for the sorted deadline timer queue: shadow timer list, beat prediction and compare.
module timer_queue_checker
  import sdtq_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic                 busy_i,
  input  logic [1:0]           opcode_i,
  input  logic [SLOT_W-1:0]    timer_slot_i,
  input  logic [IO_TIME_W-1:0] deadline_i,
  input  logic [IO_TIME_W-1:0] current_time_i,
  input  logic                 result_valid_i,
  input  logic [SLOT_W-1:0]    expired_slot_i,
  input  logic                 expired_flag_i,
  input  logic [1:0]           status_i,
  input  logic                 last_i,
  output int unsigned          fail_count_o,
  output int unsigned          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [SLOT_W-1:0]    slot;
    logic [IO_TIME_W-1:0] deadline;
  } timer_t;

  typedef struct {
    logic [SLOT_W-1:0] slot;
    logic              flag;
    status_e           status;
    logic              final_beat;
  } beat_t;

  timer_t timers[$];
  beat_t  pending_beats[$];
  beat_t  want_beat;

  assign pending_o = pending_beats.size();

  function automatic int find_timer(logic [SLOT_W-1:0] slot);
    foreach (timers[i]) begin
      if (timers[i].slot == slot) return i;
    end
    return -1;
  endfunction

  // stable insert: goes after every timer with an equal or earlier deadline
  function automatic void insert_timer(logic [SLOT_W-1:0] slot, logic [IO_TIME_W-1:0] dl);
    int     pos;
    timer_t t;
    pos = 0;
    t.slot = slot;
    t.deadline = dl;
    while (pos < timers.size() && timers[pos].deadline <= dl) pos++;
    timers.insert(pos, t);
  endfunction

  function automatic void push_beat(logic [SLOT_W-1:0] slot, logic flag, status_e sts,
                                    logic final_beat);
    beat_t b;
    b.slot = slot;
    b.flag = flag;
    b.status = sts;
    b.final_beat = final_beat;
    pending_beats.push_back(b);
  endfunction

  function automatic void predict_timer_op(op_e op, logic [SLOT_W-1:0] slot,
                                           logic [IO_TIME_W-1:0] dl,
                                           logic [IO_TIME_W-1:0] now);
    int pos;
    int n_expired;
    n_expired = 0;
    if (op == OP_TICK) begin
      while (n_expired < timers.size() && timers[n_expired].deadline <= now) n_expired++;
      if (n_expired == 0) begin
        push_beat('0, 1'b0, STS_OK, 1'b1);
      end else begin
        for (int k = 0; k < n_expired; k++) begin
          push_beat(timers[0].slot, 1'b1, STS_OK, k == n_expired - 1);
          void'(timers.pop_front());
        end
      end
    end else begin
      pos = find_timer(slot);
      if (op == OP_ADD) begin
        if (pos >= 0) begin
          push_beat('0, 1'b0, STS_PRESENT, 1'b1);
        end else if (timers.size() >= CAPACITY) begin
          push_beat('0, 1'b0, STS_FULL, 1'b1);
        end else begin
          insert_timer(slot, dl);
          push_beat('0, 1'b0, STS_OK, 1'b1);
        end
      end else if (pos < 0) begin
        push_beat('0, 1'b0, STS_ABSENT, 1'b1);
      end else begin
        timers.delete(pos);
        if (op == OP_ADJUST) insert_timer(slot, dl);
        push_beat('0, 1'b0, STS_OK, 1'b1);
      end
    end
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timers.delete();
      pending_beats.delete();
      fail_count_o = 0;
    end else begin
      if (result_valid_i) begin
        if (pending_beats.size() == 0) begin
          $display("%0t: unexpected beat, expected none actual slot %0d flag %0d status %0d last %0d",
                   $time, expired_slot_i, expired_flag_i, status_i, last_i);
          fail_count_o++;
        end else begin
          want_beat = pending_beats.pop_front();
          check_field("expired_slot", want_beat.slot, expired_slot_i);
          check_field("expired_flag", want_beat.flag, expired_flag_i);
          check_field("status", want_beat.status, status_i);
          check_field("last", want_beat.final_beat, last_i);
        end
      end
      if (start_i && !busy_i) begin
        predict_timer_op(op_e'(opcode_i), timer_slot_i, deadline_i, current_time_i);
      end
    end
  end

endmodule

// ----- verif/sorted_deadline_timer_queue_core_test.sv -----
// Testbench top of the sorted deadline timer queue: command stimulus, watchdog and verdict.
module sorted_deadline_timer_queue_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sdtq_pkg::*;

  localparam int unsigned CAPACITY    = 64;
  localparam int unsigned QUIET_LIMIT = 5000;
  localparam logic [IO_TIME_W-1:0] T_MAX = '1;

  logic                 clk_i;
  logic                 rst_ni = 1'b0;
  logic                 start_i = 1'b0;
  logic                 busy_o;
  logic [1:0]           opcode_i = OP_ADD;
  logic [SLOT_W-1:0]    timer_slot_i = '0;
  logic [IO_TIME_W-1:0] deadline_i = '0;
  logic [IO_TIME_W-1:0] current_time_i = '0;
  logic                 result_valid_o;
  logic [SLOT_W-1:0]    expired_slot_o;
  logic                 expired_flag_o;
  logic [1:0]           status_o;
  logic                 last_o;

  int unsigned          fail_count;
  int unsigned          pending;
  int unsigned          idle_pct = 14;
  logic [IO_TIME_W-1:0] clock_now = '0;

  sorted_deadline_timer_queue_core #(
    .CAPACITY (CAPACITY),
    .TIME_BITS(IO_TIME_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .opcode_i      (opcode_i),
    .timer_slot_i  (timer_slot_i),
    .deadline_i    (deadline_i),
    .current_time_i(current_time_i),
    .result_valid_o(result_valid_o),
    .expired_slot_o(expired_slot_o),
    .expired_flag_o(expired_flag_o),
    .status_o      (status_o),
    .last_o        (last_o)
  );

  timer_queue_checker #(
    .CAPACITY(CAPACITY)
  ) checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_i        (busy_o),
    .opcode_i      (opcode_i),
    .timer_slot_i  (timer_slot_i),
    .deadline_i    (deadline_i),
    .current_time_i(current_time_i),
    .result_valid_i(result_valid_o),
    .expired_slot_i(expired_slot_o),
    .expired_flag_i(expired_flag_o),
    .status_i      (status_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && !busy_o) || result_valid_o) quiet = 0;
      else quiet++;
    end
    $display("sorted_deadline_timer_queue_core_test NOT OK");
    $finish;
  end

  // start is only lowered on idle cycles, so back-to-back commands keep it high
  task automatic send_cmd(op_e op, logic [SLOT_W-1:0] slot, logic [IO_TIME_W-1:0] dl,
                          logic [IO_TIME_W-1:0] now);
    while ($urandom_range(99) < idle_pct) begin
      start_i        <= 1'b0;
      opcode_i       <= 2'($urandom);
      timer_slot_i   <= SLOT_W'($urandom);
      deadline_i     <= $urandom;
      current_time_i <= $urandom;
      @(posedge clk_i);
    end
    start_i        <= 1'b1;
    opcode_i       <= op;
    timer_slot_i   <= slot;
    deadline_i     <= dl;
    current_time_i <= now;
    do @(posedge clk_i); while (busy_o);
  endtask

  function automatic logic [IO_TIME_W-1:0] pick_deadline();
    if ($urandom_range(7) == 0) return $urandom;
    return clock_now + $urandom_range(60);
  endfunction

  task automatic random_cmds(int unsigned n);
    int unsigned       pick;
    logic [SLOT_W-1:0] slot;
    repeat (n) begin
      pick = $urandom_range(99);
      slot = ($urandom_range(3) == 0) ? SLOT_W'($urandom) : SLOT_W'($urandom_range(15));
      if (pick < 40) begin
        send_cmd(OP_ADD, slot, pick_deadline(), $urandom);
      end else if (pick < 60) begin
        send_cmd(OP_ADJUST, slot, pick_deadline(), $urandom);
      end else if (pick < 75) begin
        send_cmd(OP_DELETE, slot, $urandom, $urandom);
      end else if ($urandom_range(9) == 0) begin
        send_cmd(OP_TICK, slot, $urandom, $urandom);
      end else begin
        clock_now += $urandom_range(30);
        send_cmd(OP_TICK, slot, $urandom, clock_now);
      end
    end
  endtask

  // drain, load all 64 slots shuffled, re-add one, then expire the whole list in one tick
  task automatic fill_and_flush();
    int unsigned       order[CAPACITY];
    int unsigned       j;
    int unsigned       tmp;
    logic [SLOT_W-1:0] slot;
    for (int i = 0; i < CAPACITY; i++) order[i] = i;
    for (int i = CAPACITY - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = order[i];
      order[i] = order[j];
      order[j] = tmp;
    end
    send_cmd(OP_TICK, '0, '0, T_MAX);
    for (int i = 0; i < CAPACITY; i++) begin
      slot = SLOT_W'(order[i]);
      send_cmd(OP_ADD, slot, ($urandom_range(1) == 0) ? $urandom_range(7) : $urandom, '0);
    end
    send_cmd(OP_ADD, SLOT_W'(order[0]), '0, '0);
    send_cmd(OP_TICK, '0, '0, T_MAX);
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    send_cmd(OP_TICK,   6'd0,  32'd0,   32'd0);
    send_cmd(OP_ADD,    6'd0,  32'd0,   32'd0);
    send_cmd(OP_ADD,    6'd63, T_MAX,   T_MAX);
    send_cmd(OP_ADD,    6'd5,  32'd100, 32'd0);
    send_cmd(OP_ADD,    6'd5,  32'd100, 32'd0);
    send_cmd(OP_ADD,    6'd7,  32'd100, 32'd0);
    send_cmd(OP_ADD,    6'd9,  32'd100, 32'd0);
    send_cmd(OP_ADJUST, 6'd9,  32'd50,  32'd0);
    send_cmd(OP_ADJUST, 6'd0,  32'd200, 32'd0);
    send_cmd(OP_ADJUST, 6'd10, 32'd1,   32'd0);
    send_cmd(OP_DELETE, 6'd11, 32'd0,   32'd0);
    send_cmd(OP_DELETE, 6'd7,  32'd0,   32'd0);
    send_cmd(OP_TICK,   6'd0,  32'd0,   32'd49);
    send_cmd(OP_TICK,   6'd0,  32'd0,   32'd100);
    send_cmd(OP_ADJUST, 6'd63, 32'd0,   32'd0);
    send_cmd(OP_TICK,   6'd0,  32'd0,   32'd0);
    send_cmd(OP_TICK,   6'd0,  32'd0,   T_MAX);
    send_cmd(OP_DELETE, 6'd0,  32'd0,   32'd0);

    random_cmds(50);
    idle_pct = 0;
    random_cmds(40);
    idle_pct = 14;
    fill_and_flush();
    random_cmds(40);
    start_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("sorted_deadline_timer_queue_core_test OK");
    end else begin
      $display("sorted_deadline_timer_queue_core_test NOT OK");
    end
    $finish;
  end

endmodule
